FILE: design/mpsm_pkg.sv
// Package for the matrix power block: register codes, field widths,
// controller states and the command structs shared by the cells.
// No dependencies.
package mpsm_pkg;

    localparam int SIZE_W    = 4;
    localparam int POWER_W   = 31;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 1;
    localparam int ROW_W     = 3;

    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_POWER       = 1'b1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_INIT,
        ST_STEP,
        ST_FEED,
        ST_DRAIN,
        ST_COPY,
        ST_OUT
    } state_t;

    // broadcast to every cell
    typedef struct packed {
        logic load;
        logic init;
        logic copy;
        logic copy_acc;
        logic x_acc;
    } cell_cmd_t;

    // travels down the chain with each operand
    typedef struct packed {
        logic valid;
        logic first;
    } tok_ctrl_t;

endpackage

FILE: design/mpsm_if.sv
// Stream interfaces for the matrix power block: input elements and
// result elements. Depends on mpsm_pkg.
interface mpsm_in_if
    import mpsm_pkg::*;
#(
    parameter int DATA_WIDTH = 32
);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] element_in;

    modport source (output valid, output element_in, input ready);
    modport sink   (input valid, input element_in, output ready);
endinterface

interface mpsm_out_if
    import mpsm_pkg::*;
#(
    parameter int DATA_WIDTH = 32
);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] element_out;
    logic [ROW_W-1:0]      out_row;
    logic [ROW_W-1:0]      out_col;
    logic                  last_out;

    modport source (output valid, output element_out, output out_row, output out_col,
                    output last_out, input ready);
    modport sink   (input valid, input element_out, input out_row, input out_col,
                    input last_out, output ready);
endinterface

FILE: design/mpsm_cell.sv
// One row cell: holds a row of the base, accumulator and product matrices
// and a MAC. Operands arrive from the left neighbour. Depends on mpsm_pkg.
module mpsm_cell
    import mpsm_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int MAX_DIM    = 8,
    parameter int ROW        = 0,
    parameter int IDX_W      = 3
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cell_cmd_t             cmd,
    input  logic [IDX_W-1:0]      load_row,
    input  logic [IDX_W-1:0]      load_col,
    input  logic [DATA_WIDTH-1:0] load_data,
    input  tok_ctrl_t             tok,
    input  logic [IDX_W-1:0]      tok_k,
    input  logic [IDX_W-1:0]      tok_j,
    input  logic [DATA_WIDTH-1:0] tok_y,
    output tok_ctrl_t             tok_fwd,
    output logic [IDX_W-1:0]      tok_k_fwd,
    output logic [IDX_W-1:0]      tok_j_fwd,
    output logic [DATA_WIDTH-1:0] tok_y_fwd,
    output logic [DATA_WIDTH-1:0] arow [MAX_DIM],
    output logic [DATA_WIDTH-1:0] brow [MAX_DIM]
);

    logic [DATA_WIDTH-1:0]   arow_reg [MAX_DIM];
    logic [DATA_WIDTH-1:0]   brow_reg [MAX_DIM];
    logic [DATA_WIDTH-1:0]   srow_reg [MAX_DIM];
    tok_ctrl_t               tok_reg;
    logic [IDX_W-1:0]        k_reg;
    logic [IDX_W-1:0]        j_reg;
    logic [DATA_WIDTH-1:0]   y_reg;
    logic [DATA_WIDTH-1:0]   xval;
    logic [DATA_WIDTH-1:0]   full;
    logic [DATA_WIDTH-1:0]   sum_next;

    // only the low word of the product is kept
    always_comb
    begin
        xval     = cmd.x_acc ? arow_reg[tok_k] : brow_reg[tok_k];
        full     = xval * tok_y;
        sum_next = (tok.first ? '0 : srow_reg[tok_j]) + full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= tok_k;
        j_reg <= tok_j;
        y_reg <= tok_y;
        if (tok.valid)
        begin
            srow_reg[tok_j] <= sum_next;
        end
        if (cmd.load && load_row == IDX_W'(ROW))
        begin
            brow_reg[load_col] <= load_data;
        end
        if (cmd.init)
        begin
            for (int j = 0; j < MAX_DIM; j++)
            begin
                arow_reg[j] <= (j == ROW) ? DATA_WIDTH'(1) : '0;
            end
        end
        if (cmd.copy)
        begin
            for (int j = 0; j < MAX_DIM; j++)
            begin
                if (cmd.copy_acc)
                begin
                    arow_reg[j] <= srow_reg[j];
                end
                else
                begin
                    brow_reg[j] <= srow_reg[j];
                end
            end
        end
    end

    assign tok_fwd   = tok_reg;
    assign tok_k_fwd = k_reg;
    assign tok_j_fwd = j_reg;
    assign tok_y_fwd = y_reg;
    assign arow      = arow_reg;
    assign brow      = brow_reg;

endmodule

FILE: design/matrix_power_square_multiply.sv
// Top level of the matrix power block: controller and chain of row cells.
// Depends on mpsm_pkg, mpsm_if and mpsm_cell.
//
// Usage: write matrix_size (index 0) and power (index 1) on the cfg port
// while idle; writing matrix_size restarts a load. Then send d*d elements
// row-major on elem_stream, one transfer each, d = matrix_size clamped to
// 1..MAX_DIM. After the last element elem_stream.ready drops while the block
// computes M^power by square-and-multiply from the identity. Each product
// streams d*d operands through the cell chain (one per cycle, row k of the
// right factor against column k of each cell's row), then drains the chain
// and copies the result back, with bitlength(power)+popcount(power)
// products in all. The result then leaves on result_stream, d*d transfers
// row-major, last_out on the final one; a stalled receiver simply holds the
// current element. Loading restarts after the last result transfer. Reset
// returns size and power to 1 and clears the load position; matrix storage
// is not cleared.
module matrix_power_square_multiply
    import mpsm_pkg::*;
#(
    parameter int MAX_DIM    = 8,
    parameter int DATA_WIDTH = 32
)(
    input  logic                  clk,
    input  logic                  rst_n,
    mpsm_in_if.sink               elem_stream,
    mpsm_out_if.source            result_stream,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CNT_W = $clog2(MAX_DIM + 1);

    state_t               state_reg, state_next;
    logic [SIZE_W-1:0]    size_reg;
    logic [POWER_W-1:0]   power_reg;
    logic [POWER_W-1:0]   exp_reg, exp_next;
    logic                 acc_done_reg, acc_done_next;
    logic                 mode_reg, mode_next;
    logic [IDX_W-1:0]     r_reg, r_next;
    logic [IDX_W-1:0]     c_reg, c_next;
    logic [CNT_W-1:0]     drain_reg, drain_next;
    logic [CNT_W-1:0]     dim;
    logic [IDX_W-1:0]     dim_m1;
    cell_cmd_t            cmd;
    tok_ctrl_t            feed_tok;
    logic                 in_xfer, out_xfer;

    tok_ctrl_t             tok_c [MAX_DIM+1];
    logic [IDX_W-1:0]      tok_k [MAX_DIM+1];
    logic [IDX_W-1:0]      tok_j [MAX_DIM+1];
    logic [DATA_WIDTH-1:0] tok_y [MAX_DIM+1];
    logic [DATA_WIDTH-1:0] arow_all [MAX_DIM][MAX_DIM];
    logic [DATA_WIDTH-1:0] brow_all [MAX_DIM][MAX_DIM];

    always_comb
    begin
        if (size_reg == '0)
        begin
            dim = CNT_W'(1);
        end
        else if (size_reg > SIZE_W'(MAX_DIM))
        begin
            dim = CNT_W'(MAX_DIM);
        end
        else
        begin
            dim = CNT_W'(size_reg);
        end
        dim_m1 = IDX_W'(dim - CNT_W'(1));
    end

    assign in_xfer  = elem_stream.valid && elem_stream.ready;
    assign out_xfer = result_stream.valid && result_stream.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            size_reg     <= SIZE_W'(1);
            power_reg    <= POWER_W'(1);
            exp_reg      <= '0;
            acc_done_reg <= 1'b0;
            mode_reg     <= 1'b0;
            r_reg        <= '0;
            c_reg        <= '0;
            drain_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            exp_reg      <= exp_next;
            acc_done_reg <= acc_done_next;
            mode_reg     <= mode_next;
            r_reg        <= r_next;
            c_reg        <= c_next;
            drain_reg    <= drain_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MATRIX_SIZE:
                    begin
                        size_reg <= cfg_data[SIZE_W-1:0];
                    end
                    REG_POWER:
                    begin
                        power_reg <= cfg_data[POWER_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // r/c counters serve the load, the operand feed (k, j) and the output
    always_comb
    begin
        state_next    = state_reg;
        exp_next      = exp_reg;
        acc_done_next = acc_done_reg;
        mode_next     = mode_reg;
        r_next        = r_reg;
        c_next        = c_reg;
        drain_next    = drain_reg;
        cmd           = '0;
        cmd.x_acc     = mode_reg;
        cmd.copy_acc  = mode_reg;
        elem_stream.ready    = 1'b0;
        result_stream.valid  = 1'b0;
        feed_tok      = '0;

        unique case (state_reg)
            ST_LOAD:
            begin
                elem_stream.ready = 1'b1;
                cmd.load          = in_xfer;
                if (in_xfer)
                begin
                    if (c_reg == dim_m1)
                    begin
                        c_next = '0;
                        if (r_reg == dim_m1)
                        begin
                            r_next     = '0;
                            exp_next   = power_reg;
                            state_next = ST_INIT;
                        end
                        else
                        begin
                            r_next = r_reg + IDX_W'(1);
                        end
                    end
                    else
                    begin
                        c_next = c_reg + IDX_W'(1);
                    end
                end
            end
            ST_INIT:
            begin
                cmd.init      = 1'b1;
                acc_done_next = 1'b0;
                state_next    = ST_STEP;
            end
            ST_STEP:
            begin
                r_next = '0;
                c_next = '0;
                if (exp_reg == '0)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    mode_next  = exp_reg[0] && !acc_done_reg;
                    state_next = ST_FEED;
                end
            end
            ST_FEED:
            begin
                feed_tok.valid = 1'b1;
                feed_tok.first = (r_reg == '0);
                if (c_reg == dim_m1)
                begin
                    c_next = '0;
                    if (r_reg == dim_m1)
                    begin
                        r_next     = '0;
                        drain_next = '0;
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        r_next = r_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    c_next = c_reg + IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg + CNT_W'(1);
                if (drain_reg == CNT_W'(MAX_DIM - 1))
                begin
                    state_next = ST_COPY;
                end
            end
            ST_COPY:
            begin
                cmd.copy = 1'b1;
                if (mode_reg)
                begin
                    acc_done_next = 1'b1;
                end
                else
                begin
                    acc_done_next = 1'b0;
                    exp_next      = exp_reg >> 1;
                end
                state_next = ST_STEP;
            end
            ST_OUT:
            begin
                result_stream.valid = 1'b1;
                if (out_xfer)
                begin
                    if (c_reg == dim_m1)
                    begin
                        c_next = '0;
                        if (r_reg == dim_m1)
                        begin
                            r_next     = '0;
                            state_next = ST_LOAD;
                        end
                        else
                        begin
                            r_next = r_reg + IDX_W'(1);
                        end
                    end
                    else
                    begin
                        c_next = c_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        // a size write restarts the load position
        if (cfg_we && cfg_index == REG_MATRIX_SIZE)
        begin
            r_next = '0;
            c_next = '0;
        end
    end

    assign tok_c[0] = feed_tok;
    assign tok_k[0] = r_reg;
    assign tok_j[0] = c_reg;
    assign tok_y[0] = brow_all[r_reg][c_reg];

    assign result_stream.element_out = arow_all[r_reg][c_reg];
    assign result_stream.out_row     = ROW_W'(r_reg);
    assign result_stream.out_col     = ROW_W'(c_reg);
    assign result_stream.last_out    = (r_reg == dim_m1) && (c_reg == dim_m1);

    for (genvar i = 0; i < MAX_DIM; i++)
    begin : g_cell
        mpsm_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .MAX_DIM    (MAX_DIM),
            .ROW        (i),
            .IDX_W      (IDX_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .load_row  (r_reg),
            .load_col  (c_reg),
            .load_data (elem_stream.element_in),
            .tok       (tok_c[i]),
            .tok_k     (tok_k[i]),
            .tok_j     (tok_j[i]),
            .tok_y     (tok_y[i]),
            .tok_fwd   (tok_c[i+1]),
            .tok_k_fwd (tok_k[i+1]),
            .tok_j_fwd (tok_j[i+1]),
            .tok_y_fwd (tok_y[i+1]),
            .arow      (arow_all[i]),
            .brow      (brow_all[i])
        );
    end

endmodule
